[rtl/thruster_command_parser_core_defines.svh]
// Assertion helpers for the thruster command parser.
// All of them sample on clk_i and are quiet while rst_ni is low.
`ifndef THRUSTER_COMMAND_PARSER_CORE_DEFINES_SVH
`define THRUSTER_COMMAND_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TCP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define TCP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/tcp_pkg.sv]
`default_nettype none

package tcp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_BANG = 8'h21;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  localparam int unsigned NUM_W      = 10;
  localparam int unsigned CHAR_IDX_W = 2;
  localparam int unsigned QUOT_W     = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [NUM_W-1:0] NUM_MAX = 10'd999;

  // Reciprocal of 100 scaled by 2^22, rounded up (exact for x < 43690)
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int unsigned RECIP_SHIFT = 22;

  typedef logic [2:0] target_t;
  localparam target_t TGT_FRONT_RIGHT = 3'd0;
  localparam target_t TGT_FRONT_LEFT  = 3'd1;
  localparam target_t TGT_REAR_RIGHT  = 3'd2;
  localparam target_t TGT_REAR_LEFT   = 3'd3;
  localparam target_t TGT_DEPTH       = 3'd4;
  localparam target_t TGT_LIGHT       = 3'd5;
  localparam target_t TGT_CMD         = 3'd6;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_SET_HI,
    KIND_SET_LO,
    KIND_LIGHT,
    KIND_CMD
  } kind_e;

  typedef enum logic [2:0] {
    CMD_HOLD_ON,
    CMD_HOLD_OFF,
    CMD_ARM,
    CMD_DISARM,
    CMD_BEEP,
    CMD_BEEP_OFF
  } cmd_e;

  typedef struct packed {
    logic    valid;
    kind_e   kind;
    target_t target;
  } letter_t;

  typedef struct packed {
    logic valid;
    cmd_e cmd;
  } cmd_dec_t;

  // One decoded update, passed from front to back
  typedef struct packed {
    target_t          target;
    kind_e            kind;
    logic [NUM_W-1:0] num;
    cmd_e             cmd;
  } event_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  function automatic letter_t decode_letter(input logic [7:0] c);
    letter_t l;
    l = '{valid: 1'b1, kind: KIND_SET_HI, target: TGT_FRONT_RIGHT};
    case (c)
      "R": l = '{valid: 1'b1, kind: KIND_SET_HI, target: TGT_FRONT_RIGHT};
      "r": l = '{valid: 1'b1, kind: KIND_SET_LO, target: TGT_FRONT_RIGHT};
      "L": l = '{valid: 1'b1, kind: KIND_SET_HI, target: TGT_FRONT_LEFT};
      "l": l = '{valid: 1'b1, kind: KIND_SET_LO, target: TGT_FRONT_LEFT};
      "W": l = '{valid: 1'b1, kind: KIND_SET_HI, target: TGT_REAR_RIGHT};
      "w": l = '{valid: 1'b1, kind: KIND_SET_LO, target: TGT_REAR_RIGHT};
      "E": l = '{valid: 1'b1, kind: KIND_SET_HI, target: TGT_REAR_LEFT};
      "e": l = '{valid: 1'b1, kind: KIND_SET_LO, target: TGT_REAR_LEFT};
      "+": l = '{valid: 1'b1, kind: KIND_SET_HI, target: TGT_DEPTH};
      "-": l = '{valid: 1'b1, kind: KIND_SET_LO, target: TGT_DEPTH};
      "I": l = '{valid: 1'b1, kind: KIND_LIGHT, target: TGT_LIGHT};
      "C": l = '{valid: 1'b1, kind: KIND_CMD, target: TGT_CMD};
      default: l = '{valid: 1'b0, kind: KIND_NONE, target: TGT_FRONT_RIGHT};
    endcase
    return l;
  endfunction

  function automatic cmd_dec_t decode_command(input logic [7:0] c);
    cmd_dec_t d;
    d = '{valid: 1'b0, cmd: CMD_HOLD_ON};
    case (c)
      "H": d = '{valid: 1'b1, cmd: CMD_HOLD_ON};
      "h": d = '{valid: 1'b1, cmd: CMD_HOLD_OFF};
      "A": d = '{valid: 1'b1, cmd: CMD_ARM};
      "a": d = '{valid: 1'b1, cmd: CMD_DISARM};
      "B": d = '{valid: 1'b1, cmd: CMD_BEEP};
      "b": d = '{valid: 1'b1, cmd: CMD_BEEP_OFF};
      default: d = '{valid: 1'b0, cmd: CMD_HOLD_ON};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[rtl/tcp_front.sv]
`default_nettype none

// Byte parser: frame hunting, field letters, digit accumulation.
module tcp_front #(
  parameter int unsigned FIELD_DIGITS = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_depth_lock_i,
  input  wire logic            accept_i,
  input  wire logic [7:0]      rx_byte_i,
  output tcp_pkg::event_t      ev_o,
  output logic                 ev_valid_o
);
  import tcp_pkg::*;

  logic                  depth_lock_q;
  logic                  in_frame_q, in_frame_d;
  kind_e                 kind_q, kind_d;
  target_t               target_q, target_d;
  logic [CHAR_IDX_W-1:0] idx_q, idx_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic                  done_q, done_d;

  letter_t               letter;
  cmd_dec_t              cmd_dec;
  logic                  is_digit;
  logic [13:0]           acc;
  logic                  last_char;
  logic                  depth_blocked;

  assign letter   = decode_letter(rx_byte_i);
  assign cmd_dec  = decode_command(rx_byte_i);
  assign is_digit = (rx_byte_i >= CHAR_0) && (rx_byte_i <= CHAR_9);

  // n*10 + digit, saturated to 999 below
  assign acc = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0}
             + {10'd0, rx_byte_i[3:0]};

  assign last_char = ({1'b0, idx_q} + 3'd1) >= 3'(FIELD_DIGITS);
  assign depth_blocked = (target_q == TGT_DEPTH) && depth_lock_q;

  // Parser next state and event
  always_comb begin
    in_frame_d = in_frame_q;
    kind_d     = kind_q;
    target_d   = target_q;
    idx_d      = idx_q;
    num_d      = num_q;
    done_d     = done_q;
    ev_valid_o = 1'b0;
    ev_o       = '{target: target_q, kind: kind_q, num: num_q, cmd: CMD_HOLD_ON};

    if (accept_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == CHAR_BANG) begin
          in_frame_d = 1'b1;
        end
      end else if (rx_byte_i == CHAR_NUL) begin
        // end of frame flushes an open value field
        if (kind_q != KIND_NONE && kind_q != KIND_CMD) begin
          ev_valid_o = !depth_blocked;
        end
        in_frame_d = 1'b0;
        kind_d     = KIND_NONE;
        idx_d      = '0;
        num_d      = '0;
        done_d     = 1'b0;
      end else if (kind_q == KIND_NONE) begin
        if (letter.valid) begin
          kind_d   = letter.kind;
          target_d = letter.target;
          idx_d    = '0;
          num_d    = '0;
          done_d   = 1'b0;
        end
      end else if (kind_q == KIND_CMD) begin
        // skip, code, skip
        if (idx_q == CHAR_IDX_W'(1) && cmd_dec.valid) begin
          ev_valid_o = 1'b1;
          ev_o.cmd   = cmd_dec.cmd;
        end
        if (idx_q >= CHAR_IDX_W'(2)) begin
          kind_d = KIND_NONE;
          idx_d  = '0;
          num_d  = '0;
          done_d = 1'b0;
        end else begin
          idx_d = idx_q + CHAR_IDX_W'(1);
        end
      end else begin
        if (!done_q && is_digit) begin
          num_d = (acc > 14'(NUM_MAX)) ? NUM_MAX : acc[NUM_W-1:0];
        end else begin
          done_d = 1'b1;
        end
        if (last_char) begin
          ev_valid_o = !depth_blocked;
          ev_o.num   = num_d;
          kind_d     = KIND_NONE;
          idx_d      = '0;
          num_d      = '0;
          done_d     = 1'b0;
        end else begin
          idx_d = idx_q + CHAR_IDX_W'(1);
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_lock_q <= 1'b0;
      in_frame_q   <= 1'b0;
      kind_q       <= KIND_NONE;
      target_q     <= TGT_FRONT_RIGHT;
      idx_q        <= '0;
      num_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        depth_lock_q <= cfg_depth_lock_i;
      end
      in_frame_q <= in_frame_d;
      kind_q     <= kind_d;
      target_q   <= target_d;
      idx_q      <= idx_d;
      num_q      <= num_d;
      done_q     <= done_d;
    end
  end

endmodule

`default_nettype wire

[rtl/tcp_queue.sv]
`default_nettype none

// Small event queue between parser and scaler.
module tcp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tcp_pkg::event_t push_ev_i,
  input  wire logic            pop_i,
  output tcp_pkg::event_t      head_o,
  output tcp_pkg::q_status_t   status_o
);
  import tcp_pkg::*;

  event_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ev_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tcp_back.sv]
`default_nettype none

// Scaler: turns a queued event into the output beat, two stages.
module tcp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tcp_pkg::event_t head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [2:0]           target_o,
  output logic [14:0]          value_o,
  output logic [2:0]           command_code_o
);
  import tcp_pkg::*;

  logic               s1_valid_q;
  event_t             s1_ev_q;
  logic [QUOT_W-1:0]  s1_quot_q;
  logic               out_valid_q;
  target_t            target_q;
  logic [14:0]        value_q;
  logic [2:0]         cmd_q;

  logic               adv_out, load_s1;
  logic [10:0]        n_plus;
  logic [26:0]        prod;
  logic [13:0]        ten_n;
  logic [13:0]        scaled;
  logic [14:0]        value_d;
  logic [14:0]        light;

  assign adv_out = !out_valid_q || !out_stall_i;
  assign load_s1 = !s1_valid_q || adv_out;
  assign pop_o   = head_valid_i && load_s1;

  // ceil((n+1)/100) = floor((n+100)/100), by reciprocal multiply
  assign n_plus = {1'b0, head_i.num} + 11'd100;
  assign prod   = {16'd0, n_plus} * {11'd0, RECIP_100};

  // floor((999n-1)/100) = 10n - ceil((n+1)/100) for n > 0
  assign ten_n  = {1'b0, s1_ev_q.num, 3'b000} + {3'b000, s1_ev_q.num, 1'b0};
  assign scaled = ten_n - {10'd0, s1_quot_q};
  assign light  = {1'b0, s1_ev_q.num, 4'b0000} + {2'b00, s1_ev_q.num, 3'b000}
                + {5'd0, s1_ev_q.num};

  always_comb begin
    case (s1_ev_q.kind)
      KIND_SET_HI: value_d = (s1_ev_q.num == '0) ? 15'd1000 : {1'b0, scaled} + 15'd1000;
      KIND_SET_LO: value_d = (s1_ev_q.num == '0) ? 15'd0 : {1'b0, scaled};
      KIND_LIGHT:  value_d = light;
      default:     value_d = 15'd0;
    endcase
  end

  // Stage 1: quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load_s1) begin
      s1_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_ev_q   <= head_i;
      s1_quot_q <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      target_q <= s1_ev_q.target;
      value_q  <= value_d;
      cmd_q    <= (s1_ev_q.kind == KIND_CMD) ? s1_ev_q.cmd : 3'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_o       = target_q;
  assign value_o        = value_q;
  assign command_code_o = cmd_q;

endmodule

`default_nettype wire

[rtl/thruster_command_parser_core.sv]
`default_nettype none
`include "thruster_command_parser_core_defines.svh"

// Thruster command parser. Takes one received byte per beat, at up to one
// byte every clock while in_stall_o is low, and gives at most one update
// beat per byte: a setpoint, a light level or a command code. The parser
// decides each byte in the cycle it is accepted and drops any update into a
// two-entry queue; a two-stage scaler (reciprocal multiply, then subtract and
// offset) drains the queue through its stage 1 register into the output
// register. in_stall_o rises only while that queue is full, which happens
// only when the output side stalls. depth_lock is written through cfg_we_i
// while no update is in flight, which the user must see to: no check here.
module thruster_command_parser_core #(
  parameter int unsigned FIELD_DIGITS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_depth_lock_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       target_o,
  output logic [14:0]      value_o,
  output logic [2:0]       command_code_o
);
  import tcp_pkg::*;

  logic      accept;
  event_t    ev;
  logic      ev_valid;
  event_t    head;
  q_status_t q_status;
  logic      pop;

  assign in_stall_o = q_status.full;
  assign accept     = in_valid_i && !in_stall_o;

  tcp_front #(
    .FIELD_DIGITS(FIELD_DIGITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_depth_lock_i(cfg_depth_lock_i),
    .accept_i        (accept),
    .rx_byte_i       (rx_byte_i),
    .ev_o            (ev),
    .ev_valid_o      (ev_valid)
  );

  tcp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (ev_valid),
    .push_ev_i(ev),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  tcp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (!q_status.empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .target_o      (target_o),
    .value_o       (value_o),
    .command_code_o(command_code_o)
  );

  // Checks
  `TCP_ASSERT_IMPL(a_cmd_value_zero, out_valid_o && (target_o == TGT_CMD),
    value_o == 15'd0, "command beat with nonzero value")
  `TCP_ASSERT_IMPL(a_code_only_cmd, out_valid_o && (target_o != TGT_CMD),
    command_code_o == 3'd0, "command code on a non-command beat")
  `TCP_ASSERT_NEXT(a_empty_stays, q_status.empty && !ev_valid,
    q_status.count == '0, "queue level moved without a push")

endmodule

`default_nettype wire
